// File: src/atm_pkg.sv
package atm_pkg;

    localparam int SampleWidth  = 12;
    localparam int SumWidth     = 16;
    localparam int CodeWidth    = 8;
    localparam int RunLength    = 10;
    localparam int CountWidth   = 4;
    localparam int AvgShift     = 3;

    localparam int QueueDepth   = 2;
    localparam int QueuePtrW    = $clog2(QueueDepth);
    localparam int QueueCntW    = $clog2(QueueDepth + 1);

    // Reciprocal scaling for the constant divisors of the NTC table
    localparam int RecipShift   = 16;
    localparam int RecipWidth   = 16;
    localparam int DivWidth     = 7;

    // Segment breakpoints
    localparam logic [SampleWidth-1:0] OpenLimit = 12'd4090;
    localparam logic [SampleWidth-1:0] Knee1     = 12'd2015;
    localparam logic [SampleWidth-1:0] Knee2     = 12'd964;
    localparam logic [SampleWidth-1:0] Knee3     = 12'd474;
    localparam logic [SampleWidth-1:0] Knee4     = 12'd244;
    localparam logic [SampleWidth-1:0] Knee5     = 12'd132;
    localparam logic [SampleWidth-1:0] Knee6     = 12'd102;
    localparam logic [SampleWidth-1:0] Knee7     = 12'd82;
    localparam logic [SampleWidth-1:0] Knee8     = 12'd62;
    localparam logic [SampleWidth-1:0] Knee9     = 12'd52;
    localparam logic [SampleWidth-1:0] Knee10    = 12'd42;

    // Segment slopes
    localparam logic [DivWidth-1:0] Slope1 = 7'd104;
    localparam logic [DivWidth-1:0] Slope2 = 7'd52;
    localparam logic [DivWidth-1:0] Slope3 = 7'd25;
    localparam logic [DivWidth-1:0] Slope4 = 7'd12;
    localparam logic [DivWidth-1:0] Slope5 = 7'd6;
    localparam logic [DivWidth-1:0] SlopeUnit = 7'd1;

    // Floor of 2^RecipShift over each slope
    localparam logic [RecipWidth-1:0] Recip1 = RecipWidth'((1 << RecipShift) / int'(Slope1));
    localparam logic [RecipWidth-1:0] Recip2 = RecipWidth'((1 << RecipShift) / int'(Slope2));
    localparam logic [RecipWidth-1:0] Recip3 = RecipWidth'((1 << RecipShift) / int'(Slope3));
    localparam logic [RecipWidth-1:0] Recip4 = RecipWidth'((1 << RecipShift) / int'(Slope4));
    localparam logic [RecipWidth-1:0] Recip5 = RecipWidth'((1 << RecipShift) / int'(Slope5));

    localparam logic [CodeWidth-1:0] CodeOpen  = 8'd0;
    localparam logic [CodeWidth-1:0] CodeShort = 8'd201;

    typedef struct packed {
        logic [SumWidth-1:0]    sum;
        logic [SampleWidth-1:0] max;
        logic [SampleWidth-1:0] min;
    } run_rec_t;

endpackage

// File: src/atm_front.sv
module atm_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [11:0]               in_sample,
    input  logic                      in_timed_out,
    output logic                      push,
    output atm_pkg::run_rec_t         push_rec,
    input  logic                      queue_full
);
    import atm_pkg::*;

    logic [CountWidth-1:0]  count_reg,  count_next;
    logic [SumWidth-1:0]    sum_reg,    sum_next;
    logic [SampleWidth-1:0] max_reg,    max_next;
    logic [SampleWidth-1:0] min_reg,    min_next;
    logic                   accept;
    logic                   run_done;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        max_next = max_reg;
        min_next = min_reg;
        if (max_reg == '0) begin
            max_next = in_sample;
            min_next = in_sample;
        end else if (in_sample > max_reg) begin
            max_next = in_sample;
        end else if (in_sample < min_reg) begin
            min_next = in_sample;
        end
        sum_next   = sum_reg + SumWidth'(in_sample);
        count_next = count_reg + 1'b1;
    end

    assign run_done          = accept && !in_timed_out && (count_next == CountWidth'(RunLength));
    assign push              = run_done;
    assign push_rec.sum      = sum_next;
    assign push_rec.max      = max_next;
    assign push_rec.min      = min_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            max_reg   <= '0;
            min_reg   <= '0;
        end else if (accept) begin
            if (in_timed_out || run_done) begin
                count_reg <= '0;
                sum_reg   <= '0;
                max_reg   <= '0;
                min_reg   <= '0;
            end else begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                max_reg   <= max_next;
                min_reg   <= min_next;
            end
        end
    end

endmodule

// File: src/atm_queue.sv
module atm_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  atm_pkg::run_rec_t push_rec,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output atm_pkg::run_rec_t pop_rec
);
    import atm_pkg::*;

    run_rec_t               mem [QueueDepth];
    logic [QueuePtrW-1:0]   wr_ptr_reg;
    logic [QueuePtrW-1:0]   rd_ptr_reg;
    logic [QueueCntW-1:0]   cnt_reg;
    logic                   do_push;
    logic                   do_pop;

    assign full      = (cnt_reg == QueueCntW'(QueueDepth));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_rec   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/atm_back.sv
module atm_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rec_valid,
    output logic              rec_pop,
    input  atm_pkg::run_rec_t rec,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [11:0]       out_average,
    output logic [7:0]        out_code
);
    import atm_pkg::*;

    localparam int ProdWidth = SampleWidth + RecipWidth;

    logic en;

    // stage 1: trimmed sum and average
    logic                   v1_reg;
    logic [SampleWidth-1:0] avg1_reg, avg1_next;
    logic [SumWidth-1:0]    rest_a, rest_b;

    // stage 2: segment select
    logic                   v2_reg;
    logic [SampleWidth-1:0] avg2_reg;
    logic [SampleWidth-1:0] d2_reg,    d2_next;
    logic [DivWidth-1:0]    c2_reg,    c2_next;
    logic [RecipWidth-1:0]  m2_reg,    m2_next;
    logic [CodeWidth-1:0]   base2_reg, base2_next;
    logic                   unit2_reg, unit2_next;

    // stage 3: reciprocal product
    logic                   v3_reg;
    logic [SampleWidth-1:0] avg3_reg;
    logic [SampleWidth-1:0] d3_reg;
    logic [DivWidth-1:0]    c3_reg;
    logic [ProdWidth-1:0]   prod3_reg;
    logic [CodeWidth-1:0]   base3_reg;
    logic                   unit3_reg;

    // stage 4: correction and output
    logic                   out_valid_reg;
    logic [SampleWidth-1:0] out_avg_reg;
    logic [CodeWidth-1:0]   out_code_reg, code_next;
    logic [SampleWidth-1:0] q0, q, qc, rem;

    assign en      = !out_valid_reg || out_ready;
    assign rec_pop = en && rec_valid;

    always_comb begin
        rest_a    = (rec.sum >= SumWidth'(rec.max)) ? rec.sum - SumWidth'(rec.max) : '0;
        rest_b    = (rest_a >= SumWidth'(rec.min)) ? rest_a - SumWidth'(rec.min) : '0;
        avg1_next = SampleWidth'(rest_b >> AvgShift);
    end

    always_comb begin
        d2_next    = '0;
        c2_next    = SlopeUnit;
        m2_next    = '0;
        unit2_next = 1'b1;
        base2_next = CodeShort;
        priority if (avg1_reg > OpenLimit) begin
            base2_next = CodeOpen;
        end else if (avg1_reg > Knee1) begin
            base2_next = 8'd20;  d2_next = avg1_reg - Knee1;
            c2_next = Slope1;    m2_next = Recip1; unit2_next = 1'b0;
        end else if (avg1_reg > Knee2) begin
            base2_next = 8'd40;  d2_next = avg1_reg - Knee2;
            c2_next = Slope2;    m2_next = Recip2; unit2_next = 1'b0;
        end else if (avg1_reg > Knee3) begin
            base2_next = 8'd60;  d2_next = avg1_reg - Knee3;
            c2_next = Slope3;    m2_next = Recip3; unit2_next = 1'b0;
        end else if (avg1_reg > Knee4) begin
            base2_next = 8'd80;  d2_next = avg1_reg - Knee4;
            c2_next = Slope4;    m2_next = Recip4; unit2_next = 1'b0;
        end else if (avg1_reg > Knee5) begin
            base2_next = 8'd100; d2_next = avg1_reg - Knee5;
            c2_next = Slope5;    m2_next = Recip5; unit2_next = 1'b0;
        end else if (avg1_reg > Knee6) begin
            base2_next = 8'd140; d2_next = avg1_reg - Knee6;
        end else if (avg1_reg >= Knee7) begin
            base2_next = 8'd160; d2_next = avg1_reg - Knee7;
        end else if (avg1_reg >= Knee8) begin
            base2_next = 8'd180; d2_next = avg1_reg - Knee8;
        end else if (avg1_reg >= Knee9) begin
            base2_next = 8'd190; d2_next = avg1_reg - Knee9;
        end else if (avg1_reg >= Knee10) begin
            base2_next = 8'd200; d2_next = avg1_reg - Knee10;
        end else begin
            base2_next = CodeShort;
        end
    end

    // reciprocal quotient may fall short by one; fix with one compare
    always_comb begin
        q0        = prod3_reg[ProdWidth-1:RecipShift];
        qc        = SampleWidth'(q0 * SampleWidth'(c3_reg));
        rem       = d3_reg - qc;
        q         = unit3_reg ? d3_reg : q0 + SampleWidth'(rem >= SampleWidth'(c3_reg));
        code_next = base3_reg - q[CodeWidth-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            avg1_reg  <= avg1_next;
            avg2_reg  <= avg1_reg;
            d2_reg    <= d2_next;
            c2_reg    <= c2_next;
            m2_reg    <= m2_next;
            base2_reg <= base2_next;
            unit2_reg <= unit2_next;
            avg3_reg  <= avg2_reg;
            d3_reg    <= d2_reg;
            c3_reg    <= c2_reg;
            prod3_reg <= ProdWidth'(d2_reg) * ProdWidth'(m2_reg);
            base3_reg <= base2_reg;
            unit3_reg <= unit2_reg;
            out_avg_reg  <= avg3_reg;
            out_code_reg <= code_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg        <= rec_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_average = out_avg_reg;
    assign out_code    = out_code_reg;

endmodule

// File: src/adc_trimmed_mean_ntc_temperature.sv
// NTC thermistor front end: takes 12-bit ADC words in runs of ten, keeps a
// running sum, maximum and minimum, and after the tenth word drops the maximum
// and the minimum (floored at zero), divides by eight and returns that average
// with a temperature code from a ten-segment piecewise-linear table (0 for
// an open sensor above 4090, 201 below 42). A word with tuser set marks a
// timed-out conversion and abandons the run with no result. While the stored
// maximum is zero, a word restarts max and min. Input words are taken one per
// clock while the queue has room; the accumulator in the front stage sets that
// rate. Each finished run goes through a two-entry queue to a four-stage
// conversion pipeline (trim, segment select, reciprocal multiply, correction)
// whose stages hold while the output is stalled. The input stalls only when
// both queue entries hold runs awaiting conversion.
module adc_trimmed_mean_ntc_temperature (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
    input  logic        s_tuser,   // [0] timed_out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [11:0] average, [19:12] temperature_code, [23:20] zero
);
    import atm_pkg::*;

    run_rec_t   push_rec;
    run_rec_t   pop_rec;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_not_empty;
    logic [11:0] average;
    logic [7:0]  temp_code;

    // accumulate words, emit one record per completed run
    atm_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_sample    (s_tdata[11:0]),
        .in_timed_out (s_tuser),
        .push         (push),
        .push_rec     (push_rec),
        .queue_full   (q_full)
    );

    // decouple accumulation from conversion
    atm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_rec  (push_rec),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_rec   (pop_rec)
    );

    // trim, average and map to temperature code
    atm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rec_valid   (q_not_empty),
        .rec_pop     (pop),
        .rec         (pop_rec),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_average (average),
        .out_code    (temp_code)
    );

    assign m_tdata = {4'b0000, temp_code, average};

endmodule

// File: verif/ntc_reading_checker.sv
`timescale 1ns / 100ps

module ntc_reading_checker
    import atm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
    input  logic        s_tuser,   // [0] timed_out
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [11:0] average, [19:12] temperature_code, [23:20] zero
    output int          fail_count,
    output int          pending_results
);

    typedef struct packed {
        logic [SampleWidth-1:0] average;
        logic [CodeWidth-1:0]   code;
    } ntc_reading_t;

    ntc_reading_t            readings_due[$];
    logic [CountWidth-1:0]   run_count;
    logic [SumWidth-1:0]     run_sum;
    logic [SampleWidth-1:0]  run_max;
    logic [SampleWidth-1:0]  run_min;
    int                      fails = 0;

    function void restart_run();
        run_count = '0;
        run_sum   = '0;
        run_max   = '0;
        run_min   = '0;
    endfunction

    // Piecewise-linear NTC curve: breakpoints fall, code rises as the average drops
    function automatic logic [CodeWidth-1:0] code_for_average(input logic [SampleWidth-1:0] avg);
        int v;
        v = int'(avg);
        if (v > int'(OpenLimit)) return CodeOpen;
        if (v > int'(Knee1)) return CodeWidth'(20 - (v - int'(Knee1)) / int'(Slope1));
        if (v > int'(Knee2)) return CodeWidth'(40 - (v - int'(Knee2)) / int'(Slope2));
        if (v > int'(Knee3)) return CodeWidth'(60 - (v - int'(Knee3)) / int'(Slope3));
        if (v > int'(Knee4)) return CodeWidth'(80 - (v - int'(Knee4)) / int'(Slope4));
        if (v > int'(Knee5)) return CodeWidth'(100 - (v - int'(Knee5)) / int'(Slope5));
        if (v > int'(Knee6)) return CodeWidth'(140 - (v - int'(Knee6)));
        if (v >= int'(Knee7)) return CodeWidth'(160 - (v - int'(Knee7)));
        if (v >= int'(Knee8)) return CodeWidth'(180 - (v - int'(Knee8)));
        if (v >= int'(Knee9)) return CodeWidth'(190 - (v - int'(Knee9)));
        if (v >= int'(Knee10)) return CodeWidth'(200 - (v - int'(Knee10)));
        return CodeShort;
    endfunction

    always @(posedge aclk) begin
        ntc_reading_t            got;
        ntc_reading_t            want;
        logic [SumWidth-1:0]     rest;
        logic [SampleWidth-1:0]  smp;
        if (!aresetn) begin
            restart_run();
            readings_due.delete();
        end else begin
            // compare the result word first; a run's result never leaves on its own input edge
            if (m_tvalid && m_tready) begin
                got.average = m_tdata[11:0];
                got.code    = m_tdata[19:12];
                if (readings_due.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: unexpected result word: average %0d code %0d",
                                 $realtime, got.average, got.code);
                    fails++;
                end else begin
                    want = readings_due.pop_front();
                    if (got.average !== want.average || got.code !== want.code) begin
                        if (fails < 10)
                            $display("%0t: mismatch: expected average %0d code %0d, got average %0d code %0d",
                                     $realtime, want.average, want.code, got.average, got.code);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                smp = s_tdata[11:0];
                if (s_tuser) begin
                    restart_run();
                end else begin
                    // a zero maximum means no sample seen yet: restart max and min
                    if (run_max == '0) begin
                        run_max = smp;
                        run_min = smp;
                    end else if (smp > run_max) begin
                        run_max = smp;
                    end else if (smp < run_min) begin
                        run_min = smp;
                    end
                    run_sum   = run_sum + SumWidth'(smp);
                    run_count = run_count + 1'b1;
                    if (run_count == CountWidth'(RunLength)) begin
                        rest = (run_sum >= SumWidth'(run_max)) ? run_sum - SumWidth'(run_max) : '0;
                        rest = (rest >= SumWidth'(run_min)) ? rest - SumWidth'(run_min) : '0;
                        want.average = rest[AvgShift +: SampleWidth];
                        want.code    = code_for_average(want.average);
                        readings_due.push_back(want);
                        restart_run();
                    end
                end
            end
        end
        fail_count      <= fails;
        pending_results <= readings_due.size();
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import atm_pkg::*;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [11:0] sample, [15:12] zero
    logic        s_tuser  = 1'b0;  // [0] timed_out
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // [11:0] average, [19:12] temperature_code, [23:20] zero

    // steady: a long stretch where neither side idles
    logic        steady = 1'b0;
    int          fail_count;
    int          pending_results;
    int          words_sent = 0;

    adc_trimmed_mean_ntc_temperature dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ntc_reading_checker checker_inst (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Stall the result side about 27 percent of the time, never in the steady stretch
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 27);
    end

    // Offer one word and hold it until the block takes it. Idle gaps are
    // inserted before the word, so tvalid only drops when a gap follows.
    task automatic send_word(input logic [SampleWidth-1:0] smp, input logic timed_out);
        while (!steady && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, smp};
        s_tuser  <= timed_out;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // Draw a sample around a level, clamped to the ADC range
    function automatic logic [SampleWidth-1:0] near_level(input int level, input int spread);
        int v;
        v = level - spread + int'($urandom_range(2 * spread));
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return SampleWidth'(v);
    endfunction

    // One run of ten words clustered around a level, so the trimmed average
    // lands in a chosen segment of the table. Rare timeouts break the run,
    // and some runs sprinkle zeros to exercise the max-is-zero restart.
    task automatic send_random_run();
        int level;
        int spread;
        int sprinkle_zeros;
        int i;
        case ($urandom_range(5))
            0:       level = $urandom_range(140);
            1:       level = $urandom_range(500, 100);
            2:       level = $urandom_range(2100, 450);
            3:       level = $urandom_range(4095, 1900);
            4:       level = $urandom_range(4095, 4070);
            default: level = $urandom_range(4095);
        endcase
        case ($urandom_range(3))
            0:       spread = 0;
            1:       spread = 3;
            2:       spread = 40;
            default: spread = 4095;
        endcase
        sprinkle_zeros = ($urandom_range(9) == 0);
        for (i = 0; i < RunLength; i++) begin
            if ($urandom_range(99) < 3)
                send_word(SampleWidth'($urandom), 1'b1);
            else if (sprinkle_zeros && $urandom_range(3) == 0)
                send_word('0, 1'b0);
            else
                send_word(near_level(level, spread), 1'b0);
        end
    endtask

    initial begin
        int i;
        int guard;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Timeout with no run in progress
        send_word(SampleWidth'($urandom), 1'b1);
        // Timeout in the middle of a run: drop the three words already taken
        for (i = 0; i < 3; i++)
            send_word(SampleWidth'($urandom_range(4095, 1)), 1'b0);
        send_word(12'hFFF, 1'b1);
        // Leading zeros keep restarting max and min; the lone nonzero word is
        // both max and min, so the second trim step floors at zero
        for (i = 0; i < 9; i++)
            send_word('0, 1'b0);
        send_word(12'hFFF, 1'b0);
        // Full-scale run: a single distinct value, average above the open limit
        for (i = 0; i < RunLength; i++)
            send_word(12'hFFF, 1'b0);

        // Random runs, with a long steady stretch in the middle
        while (words_sent < 525) begin
            steady <= (words_sent >= 220 && words_sent < 340);
            send_random_run();
        end
        steady   <= 1'b0;
        s_tvalid <= 1'b0;

        // Drain: wait for every expected result, then let the pipeline settle
        guard = 0;
        do begin
            @(posedge aclk);
            guard++;
        end while (pending_results != 0 && guard < 4000);
        repeat (16) @(posedge aclk);

        if (fail_count == 0 && pending_results == 0) begin
            $display("adc_trimmed_mean_ntc_temperature verification clean");
        end else begin
            $display("adc_trimmed_mean_ntc_temperature verification failed");
        end
        $finish;
    end

    // Hard stop if the handshakes ever hang
    initial begin
        #400000;
        $display("adc_trimmed_mean_ntc_temperature verification failed");
        $finish;
    end

endmodule

// File: sim.f
src/atm_pkg.sv
src/atm_front.sv
src/atm_queue.sv
src/atm_back.sv
src/adc_trimmed_mean_ntc_temperature.sv
verif/ntc_reading_checker.sv
verif/tb_top.sv
